// ===== sv/msa_pkg.sv =====
// Package for the masked vector scatter-add core.
// Shared types, field widths and codes. No dependencies.
package msa_pkg;

  localparam int LANES             = 4;
  localparam int LANE_W            = 2;
  localparam int IDX_W             = 10;
  localparam int VAL_W             = 32;
  localparam int TABLE_DEPTH_DEF   = 1024;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LANE
  } state_t;

  // One table access handed from the sequencer to the update stage
  typedef struct packed {
    logic             vld;       // an access was issued this cycle
    logic             wr;        // lane add: read-modify-write
    logic             rd;        // read item: result goes out
    logic             clr;       // clearing pass: write zero
    logic             in_range;  // read index inside the table
    logic [VAL_W-1:0] value;     // amount to add
  } issue_t;

endpackage

// ===== sv/msa_table.sv =====
// Counter table: one write port, one read port, registered read data.
// Depends on msa_pkg.
module msa_table #(
  parameter int TABLE_DEPTH = msa_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [msa_pkg::VAL_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [msa_pkg::VAL_W-1:0] rd_data
);

  logic [msa_pkg::VAL_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read sees the old word when written at the same edge; the update stage forwards
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/msa_issue.sv =====
// Sequencer: clearing pass after reset, input beat acceptance, one lane per cycle.
// Depends on msa_pkg.
module msa_issue #(
  parameter int TABLE_DEPTH = msa_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [msa_pkg::IDX_W-1:0]   lane_index_a,
  input  logic [msa_pkg::IDX_W-1:0]   lane_index_b,
  input  logic [msa_pkg::IDX_W-1:0]   lane_index_c,
  input  logic [msa_pkg::IDX_W-1:0]   lane_index_d,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_a,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_b,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_c,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_d,
  input  logic [msa_pkg::LANES-1:0]   lane_active,
  input  logic [msa_pkg::IDX_W-1:0]   read_index,
  input  logic                        rd_free,
  output msa_pkg::issue_t             iss,
  output logic [ADDR_W-1:0]           iss_addr
);

  localparam int EXT_W = (ADDR_W > msa_pkg::IDX_W) ? ADDR_W : msa_pkg::IDX_W;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(TABLE_DEPTH - 1);

  msa_pkg::state_t state, state_next;
  logic [msa_pkg::LANE_W-1:0] lane;
  logic [ADDR_W-1:0]          clr_cnt;

  // latched update item
  logic [ADDR_W-1:0]          item_addr  [msa_pkg::LANES];
  logic [msa_pkg::VAL_W-1:0]  item_value [msa_pkg::LANES];
  logic [msa_pkg::LANES-1:0]  item_use;

  logic [msa_pkg::IDX_W-1:0]  port_idx [msa_pkg::LANES];
  logic [msa_pkg::VAL_W-1:0]  port_val [msa_pkg::LANES];
  logic [EXT_W-1:0]           port_ext [msa_pkg::LANES];
  logic [msa_pkg::LANES-1:0]  port_range;
  logic [EXT_W-1:0]           rd_ext;
  logic                       rd_range;
  logic                       acc;

  assign port_idx[0] = lane_index_a;
  assign port_idx[1] = lane_index_b;
  assign port_idx[2] = lane_index_c;
  assign port_idx[3] = lane_index_d;
  assign port_val[0] = lane_value_a;
  assign port_val[1] = lane_value_b;
  assign port_val[2] = lane_value_c;
  assign port_val[3] = lane_value_d;

  always_comb begin
    for (int k = 0; k < msa_pkg::LANES; k++) begin
      port_ext[k]   = EXT_W'(port_idx[k]);
      port_range[k] = 32'(port_idx[k]) < 32'(TABLE_DEPTH);
    end
  end

  assign rd_ext   = EXT_W'(read_index);
  assign rd_range = 32'(read_index) < 32'(TABLE_DEPTH);
  assign acc      = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      msa_pkg::ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) state_next = msa_pkg::ST_IDLE;
      end
      msa_pkg::ST_IDLE: begin
        if (acc && mode == msa_pkg::MODE_UPDATE) state_next = msa_pkg::ST_LANE;
      end
      msa_pkg::ST_LANE: begin
        if (lane == msa_pkg::LANE_W'(msa_pkg::LANES - 1) && !acc) begin
          state_next = msa_pkg::ST_IDLE;
        end
      end
      default: state_next = msa_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    iss      = '0;
    iss_addr = '0;
    unique case (state)
      msa_pkg::ST_CLEAR: begin
        iss.vld  = 1'b1;
        iss.clr  = 1'b1;
        iss_addr = clr_cnt;
      end
      msa_pkg::ST_IDLE: begin
        in_ready = (mode == msa_pkg::MODE_UPDATE) || rd_free;
        // read beats go straight to the table port
        if (in_valid && in_ready && mode == msa_pkg::MODE_READ) begin
          iss.vld      = 1'b1;
          iss.rd       = 1'b1;
          iss.in_range = rd_range;
          iss_addr     = rd_ext[ADDR_W-1:0];
        end
      end
      msa_pkg::ST_LANE: begin
        in_ready = (lane == msa_pkg::LANE_W'(msa_pkg::LANES - 1)) &&
                   (mode == msa_pkg::MODE_UPDATE);
        iss.vld   = 1'b1;
        iss.wr    = item_use[lane];
        iss.value = item_value[lane];
        iss_addr  = item_addr[lane];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= msa_pkg::ST_CLEAR;
      lane    <= '0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      lane    <= (state == msa_pkg::ST_LANE) ? lane + 1'b1 : '0;
      if (state == msa_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && mode == msa_pkg::MODE_UPDATE) begin
      for (int k = 0; k < msa_pkg::LANES; k++) begin
        item_addr[k]  <= port_ext[k][ADDR_W-1:0];
        item_value[k] <= port_val[k];
      end
      item_use <= lane_active & port_range;
    end
  end

endmodule

// ===== sv/msa_update.sv =====
// Update stage: forwards the last write, adds, writes back, holds the read result.
// Depends on msa_pkg.
module msa_update #(
  parameter int TABLE_DEPTH = msa_pkg::TABLE_DEPTH_DEF,
  parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  msa_pkg::issue_t                  iss,
  input  logic [ADDR_W-1:0]                iss_addr,
  input  logic [msa_pkg::VAL_W-1:0]        rd_data,
  output logic                             wr_en,
  output logic [ADDR_W-1:0]                wr_addr,
  output logic [msa_pkg::VAL_W-1:0]        wr_data,
  output logic                             rd_free,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [msa_pkg::VAL_W-1:0] read_value
);

  msa_pkg::issue_t           s2;
  logic [ADDR_W-1:0]         s2_addr;
  logic                      fwd_vld;
  logic [ADDR_W-1:0]         fwd_addr;
  logic [msa_pkg::VAL_W-1:0] fwd_data;
  logic [msa_pkg::VAL_W-1:0] cur;

  // a write at the edge of the read is not in rd_data yet
  assign cur = (fwd_vld && fwd_addr == s2_addr) ? fwd_data : rd_data;

  assign wr_en   = s2.vld && (s2.wr || s2.clr);
  assign wr_addr = s2_addr;
  assign wr_data = s2.clr ? '0 : cur + s2.value;
  assign rd_free = !out_valid && !(s2.vld && s2.rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2        <= '0;
      fwd_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s2 <= iss;
      if (wr_en) fwd_vld <= 1'b1;
      if (s2.vld && s2.rd) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_addr <= iss_addr;
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
    if (s2.vld && s2.rd) read_value <= s2.in_range ? cur : '0;
  end

endmodule

// ===== sv/masked_vector_scatter_add_core.sv =====
// Top level of the masked vector scatter-add core.
// Depends on msa_pkg, msa_table, msa_issue, msa_update.
//
//   channel | signals                                  | beat
//   input   | in_valid / in_ready, mode, lane_*, read_index | update or read item
//   output  | out_valid / out_ready, read_value        | one per read item
//
// After reset a clearing pass zeroes the table, with in_ready low.
// Update beat: one lane per cycle through the single table write port;
// the next update is taken in the cycle of the last lane.
// Read beat: issued in the accept cycle; the result goes through the table read register and s2 into read_value.
// A read is taken only when the output register is empty; updates keep flowing
// while a result waits for out_ready.
module masked_vector_scatter_add_core #(
  parameter int TABLE_DEPTH = msa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [msa_pkg::IDX_W-1:0]        lane_index_a,
  input  logic [msa_pkg::IDX_W-1:0]        lane_index_b,
  input  logic [msa_pkg::IDX_W-1:0]        lane_index_c,
  input  logic [msa_pkg::IDX_W-1:0]        lane_index_d,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_a,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_b,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_c,
  input  logic signed [msa_pkg::VAL_W-1:0] lane_value_d,
  input  logic [msa_pkg::LANES-1:0]        lane_active,
  input  logic [msa_pkg::IDX_W-1:0]        read_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [msa_pkg::VAL_W-1:0] read_value
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  msa_pkg::issue_t           iss;
  logic [ADDR_W-1:0]         iss_addr;
  logic [msa_pkg::VAL_W-1:0] rd_data;
  logic                      wr_en;
  logic [ADDR_W-1:0]         wr_addr;
  logic [msa_pkg::VAL_W-1:0] wr_data;
  logic                      rd_free;

  msa_issue #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_issue (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .lane_index_a (lane_index_a),
    .lane_index_b (lane_index_b),
    .lane_index_c (lane_index_c),
    .lane_index_d (lane_index_d),
    .lane_value_a (lane_value_a),
    .lane_value_b (lane_value_b),
    .lane_value_c (lane_value_c),
    .lane_value_d (lane_value_d),
    .lane_active  (lane_active),
    .read_index   (read_index),
    .rd_free      (rd_free),
    .iss          (iss),
    .iss_addr     (iss_addr)
  );

  msa_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (iss_addr),
    .rd_data (rd_data)
  );

  msa_update #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .iss        (iss),
    .iss_addr   (iss_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_free    (rd_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_value (read_value)
  );

endmodule
